// File: src/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

	// widest pattern the register file can hold
	localparam int REG_BYTES  = 16;
	localparam int PAT_IDX_W  = $clog2(REG_BYTES);
	localparam int LEN_W      = 5;
	localparam int CARE_W     = 16;
	localparam int CFG_DATA_W = 64;
	localparam int RES_OFF_W  = 32;

	typedef enum logic [1:0] {
		REG_PAT_LO  = 2'd0,
		REG_PAT_HI  = 2'd1,
		REG_CARE    = 2'd2,
		REG_PAT_LEN = 2'd3
	} cfg_reg_t;

	typedef logic [REG_BYTES-1:0][7:0] pat_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic                 found;
		logic [RES_OFF_W-1:0] match_offset;
	} out_word_t;

	// per-word control shared by every cell of the window
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/wbps_cell.sv
`default_nettype none

module wbps_cell #(
	parameter int IDX = 0
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire wbps_pkg::cell_ctrl_t                ctrl,
	input  wire logic [7:0]                          byte_in,
	input  wire logic                                valid_in,
	input  wire wbps_pkg::pat_t                      pattern,
	input  wire logic [wbps_pkg::CARE_W-1:0]         care,
	input  wire logic [wbps_pkg::LEN_W-1:0]          eff_len,
	output logic [7:0]                               byte_out,
	output logic                                     valid_out,
	output logic                                     ok
);
	import wbps_pkg::*;

	localparam logic [LEN_W-1:0] CELL_POS = LEN_W'(IDX);

	logic [7:0]           byte_q;
	logic                 valid_q;
	logic                 in_use;
	logic [LEN_W-1:0]     j_full;
	logic [PAT_IDX_W-1:0] j;

	// this cell lines up with pattern byte len-1-idx
	assign in_use = eff_len > CELL_POS;
	assign j_full = eff_len - CELL_POS - LEN_W'(1);
	assign j      = j_full[PAT_IDX_W-1:0];

	// compare against the byte this cell is about to hold
	assign ok = !in_use || (valid_in && (!care[j] || byte_in == pattern[j]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out  = byte_q;
	assign valid_out = valid_q;

endmodule

`default_nettype wire

// File: src/wildcard_byte_pattern_search_top.sv
// a result word appears on out in the cycle after the byte that completes a match
//   or the last byte of a buffer with no match reported yet is accepted
// throughput: one byte per cycle unless a result waits; cell compares are combinational
// reset: arst_n clears the pattern registers, window valid bits, byte position,
//   report flag and output valid; no clearing pass is needed
`default_nettype none

module wildcard_byte_pattern_search_top #(
	parameter int PATTERN_MAX = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire wbps_pkg::in_word_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output wbps_pkg::out_word_t                  out_data,
	input  wire logic                            cfg_we,
	input  wire wbps_pkg::cfg_reg_t              cfg_index,
	input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wbps_pkg::*;

	// cells beyond the register file width can never be compared
	localparam int LIMIT = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	// configuration registers
	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [CARE_W-1:0]     care_q;
	logic [LEN_W-1:0]      len_q;

	// buffer state
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   reported_q;

	// output register
	logic      out_valid_q;
	out_word_t out_data_q;

	logic                  in_fire;
	cell_ctrl_t            ctrl;
	pat_t                  pattern;
	logic [LEN_W-1:0]      eff_len;
	logic [LIMIT-1:0][7:0] win_byte;
	logic [LIMIT-1:0]      win_valid;
	logic [LIMIT-1:0]      cell_ok;
	logic                  match;
	logic                  emit;
	logic [OFFSET_BITS-1:0] len_m1;
	logic [OFFSET_BITS-1:0] start;
	logic [RES_OFF_W-1:0]  start_res;
	out_word_t             res;

	// ---------------------------------------------------------------
	// configuration writes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			len_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LO:  pat_lo_q <= cfg_wdata;
				REG_PAT_HI:  pat_hi_q <= cfg_wdata;
				REG_CARE:    care_q   <= cfg_wdata[CARE_W-1:0];
				REG_PAT_LEN: len_q    <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pattern = {pat_hi_q, pat_lo_q};
	// clamp the length to the cells actually built
	assign eff_len = (len_q > LEN_W'(LIMIT)) ? LEN_W'(LIMIT) : len_q;

	// ---------------------------------------------------------------
	// handshake: input stalls only while a result word waits
	// ---------------------------------------------------------------
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign ctrl.shift = in_fire;
	assign ctrl.clear = in_fire && in_data.last_byte;

	// ---------------------------------------------------------------
	// window: row of cells, newest byte enters cell 0
	// ---------------------------------------------------------------
	for (genvar k = 0; k < LIMIT; k++) begin : g_cell
		if (k == 0) begin : g_head
			wbps_cell #(.IDX(k)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.byte_in   (in_data.data_byte),
				.valid_in  (1'b1),
				.pattern   (pattern),
				.care      (care_q),
				.eff_len   (eff_len),
				.byte_out  (win_byte[k]),
				.valid_out (win_valid[k]),
				.ok        (cell_ok[k])
			);
		end else begin : g_body
			wbps_cell #(.IDX(k)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.byte_in   (win_byte[k-1]),
				.valid_in  (win_valid[k-1]),
				.pattern   (pattern),
				.care      (care_q),
				.eff_len   (eff_len),
				.byte_out  (win_byte[k]),
				.valid_out (win_valid[k]),
				.ok        (cell_ok[k])
			);
		end
	end

	// a zero length never matches; a cell not yet filled fails its compare
	assign match = (eff_len != '0) && (&cell_ok) && !reported_q;
	assign emit  = match || (in_data.last_byte && !reported_q);

	// start offset = position of this byte minus (len - 1), floored at zero
	assign len_m1 = OFFSET_BITS'(eff_len) - OFFSET_BITS'(1);
	assign start  = (pos_q >= len_m1) ? (pos_q - len_m1) : '0;

	if (OFFSET_BITS >= RES_OFF_W) begin : g_off_trunc
		assign start_res = start[RES_OFF_W-1:0];
	end else begin : g_off_ext
		assign start_res = RES_OFF_W'(start);
	end

	always_comb begin
		res.found        = match;
		res.match_offset = match ? start_res : '0;
	end

	// ---------------------------------------------------------------
	// position counter and report flag, rearmed by the last byte
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (in_fire) begin
			if (in_data.last_byte) begin
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				// saturating byte position
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + OFFSET_BITS'(1);
				end
				reported_q <= reported_q || match;
			end
		end
	end

	// ---------------------------------------------------------------
	// result word register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.last_byte |=> pos_q == '0 && !reported_q && win_valid == '0)
		else $error("last byte did not rearm the search");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_fire))
		else $error("result word without an accepted byte");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !in_ready)
		else $error("byte taken while a result word is stalled");

	a_one_report: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && match && !in_data.last_byte |=> reported_q)
		else $error("match not recorded for the buffer");

	a_miss_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.found |-> out_data_q.match_offset == '0)
		else $error("not-found word carries an offset");

endmodule

`default_nettype wire

// File: tb/pattern_search_checker.sv
module pattern_search_checker #(
	parameter int PATTERN_MAX = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire wbps_pkg::in_word_t              in_data,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire wbps_pkg::out_word_t             out_data,
	input  wire logic                            cfg_we,
	input  wire wbps_pkg::cfg_reg_t              cfg_index,
	input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                                   mismatches,
	output int                                   outstanding
);
	import wbps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_LEN = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;

	// register copies
	pat_t              pattern;
	logic [CARE_W-1:0] care;
	logic [LEN_W-1:0]  pat_len;

	// scan state, newest byte at index 0
	logic [7:0]             window [PATTERN_MAX];
	int                     fill;
	logic [OFFSET_BITS-1:0] byte_pos;
	logic                   reported;

	out_word_t expected_reports [$];

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic rearm_scan();
		for (int k = 0; k < PATTERN_MAX; k++)
			window[k] = '0;
		fill = 0;
		byte_pos = '0;
		reported = 1'b0;
	endtask

	// one byte into the window; queues the report it completes, if any, or a not-found report on an unreported last byte
	task automatic scan_byte(input in_word_t w);
		logic [OFFSET_BITS-1:0] here;
		int unsigned            span;
		logic                   hit;
		logic [63:0]            start;
		out_word_t              rep;
		here = byte_pos;
		for (int k = PATTERN_MAX - 1; k > 0; k--)
			window[k] = window[k-1];
		window[0] = w.data_byte;
		if (fill < PATTERN_MAX)
			fill++;
		if (byte_pos != '1)
			byte_pos++;
		span = (pat_len > LIMIT_LEN) ? LIMIT_LEN : pat_len;
		hit = !reported && span > 0 && fill >= span;
		for (int j = 0; j < span; j++)
			if (care[j] && pattern[j] != window[span-1-j])
				hit = 1'b0;
		if (hit) begin
			start = (here >= span - 1) ? here - (span - 1) : '0;
			rep.found = 1'b1;
			rep.match_offset = start[RES_OFF_W-1:0];
			expected_reports = {expected_reports, rep};
			reported = 1'b1;
		end
		if (w.last_byte) begin
			if (!reported) begin
				rep.found = 1'b0;
				rep.match_offset = '0;
				expected_reports = {expected_reports, rep};
			end
			rearm_scan();
		end
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			pattern = '0;
			care = '0;
			pat_len = '0;
			rearm_scan();
			expected_reports.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					flag_mismatch("unexpected result word", 64'(out_data), '0);
				end else begin
					want = expected_reports.pop_front();
					if (out_data.found !== want.found)
						flag_mismatch("found", 64'(out_data.found), 64'(want.found));
					if (out_data.match_offset !== want.match_offset)
						flag_mismatch("match_offset", 64'(out_data.match_offset),
							64'(want.match_offset));
				end
			end
			// a byte taken at this edge still sees the old registers
			if (in_valid && in_ready)
				scan_byte(in_data);
			if (cfg_we) begin
				case (cfg_index)
					REG_PAT_LO:  pattern[7:0] = cfg_wdata;
					REG_PAT_HI:  pattern[15:8] = cfg_wdata;
					REG_CARE:    care = cfg_wdata[CARE_W-1:0];
					REG_PAT_LEN: pat_len = cfg_wdata[LEN_W-1:0];
					default:     ;
				endcase
			end
		end
		outstanding = expected_reports.size();
	end

endmodule

// File: tb/wildcard_byte_pattern_search_top_test.sv
module wildcard_byte_pattern_search_top_test;
	import wbps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 750;
	localparam int CALM_AFTER  = 650;   // no idling on either side past this many words
	localparam int DRAIN_WAIT  = 4;     // a result is registered in the cycle after its byte is taken

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_word_t             out_data;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    outstanding;

	// copy of the programmed pattern, used to plant matches in the stream
	pat_t              cur_pat;
	logic [CARE_W-1:0] cur_care;
	logic [LEN_W-1:0]  cur_len;
	int                sent;
	bit                calm;

	wildcard_byte_pattern_search_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pattern_search_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stall bursts, long open stretches, always open once calm
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			out_ready = 1'b1;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(20, 60)) @(negedge clk);
			else
				repeat ($urandom_range(0, 8)) @(negedge clk);
		end
	end

	// one byte word: optional gap, then hold valid until the handshake
	task automatic send_word(input in_word_t w);
		bit ok;
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = w;
		forever begin
			// ready settles after the falling-edge drive and holds until the rise
			#1 ok = in_ready;
			@(posedge clk);
			if (ok)
				break;
			@(negedge clk);
		end
		sent++;
	endtask

	// stop sending and let every pending result come back
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// block must be idle here: caller drains first
	task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
			input logic [CARE_W-1:0] care, input logic [LEN_W-1:0] len);
		write_reg(REG_PAT_LO, lo);
		write_reg(REG_PAT_HI, hi);
		write_reg(REG_CARE, {{(CFG_DATA_W-CARE_W){1'b0}}, care});
		write_reg(REG_PAT_LEN, {{(CFG_DATA_W-LEN_W){1'b0}}, len});
		cur_pat[7:0] = lo;
		cur_pat[15:8] = hi;
		cur_care = care;
		cur_len = len;
	endtask

	task automatic send_bytes(input logic [7:0] bytes [$], input bit close);
		in_word_t w;
		foreach (bytes[i]) begin
			w.data_byte = bytes[i];
			w.last_byte = close && (i == bytes.size() - 1);
			send_word(w);
		end
	endtask

	// random buffer, mostly with the pattern planted somewhere inside it
	task automatic send_buffer(input int n, input bit close);
		logic [7:0] bytes [$];
		int         span;
		int         at;
		bit         plant;
		bit         near;
		logic [7:0] b;
		span = (cur_len > REG_BYTES) ? REG_BYTES : cur_len;
		plant = span > 0 && n >= span && $urandom_range(0, 9) < 7;
		at = plant ? $urandom_range(0, n - span) : -1;
		// near: filler drawn from the pattern itself to provoke partial matches
		near = span > 0 && $urandom_range(0, 2) == 0;
		for (int i = 0; i < n; i++) begin
			if (plant && i >= at && i < at + span && cur_care[i-at])
				b = cur_pat[i-at];
			else if (near)
				b = cur_pat[$urandom_range(0, span - 1)];
			else
				b = 8'($urandom);
			bytes = {bytes, b};
		end
		send_bytes(bytes, close);
	endtask

	initial begin
		logic [63:0]       lo;
		logic [63:0]       hi;
		logic [CARE_W-1:0] care;
		logic [LEN_W-1:0]  len;
		int                nbuf;
		int                blen;
		int                pick;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_PAT_LO;
		cfg_wdata = '0;
		sent = 0;
		calm = 1'b0;
		cur_pat = '0;
		cur_care = '0;
		cur_len = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero length out of reset: never matches, not-found on the last byte
		send_bytes('{8'h00, 8'hFF, 8'h00}, 1'b1);

		// four exact bytes, match completing on the last byte of the buffer
		drain_results();
		set_pattern(64'h0000_0000_EFBE_ADDE, 64'h0, 16'h000F, 5'd4);
		send_bytes('{8'h11, 8'hDE, 8'hAD, 8'hBE, 8'hEF}, 1'b1);

		// pattern split across a buffer boundary must not match
		drain_results();
		set_pattern(64'h0000_0000_0000_CDAB, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0003, 5'd2);
		send_bytes('{8'hAB}, 1'b1);
		send_bytes('{8'hCD}, 1'b1);

		// overlong length clamps to sixteen, upper half all wildcards
		drain_results();
		set_pattern(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'h00FF, 5'd31);
		send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'h5A, 8'hA5, 8'h80, 8'h01, 8'h7F, 8'hC3, 8'h3C}, 1'b1);

		// random phases; an open buffer may carry across a register change
		while (sent < ITEM_TARGET) begin
			drain_results();
			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = 5'd0;
			else if (pick == 1)
				len = 5'd16;
			else if (pick == 2)
				len = LEN_W'($urandom_range(17, 31));
			else if (pick == 3)
				len = 5'd1;
			else
				len = LEN_W'($urandom_range(2, 8));
			pick = $urandom_range(0, 3);
			care = (pick == 0) ? '1 : (pick == 1) ? '0 : CARE_W'($urandom);
			pick = $urandom_range(0, 7);
			lo = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
			pick = $urandom_range(0, 7);
			hi = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
			set_pattern(lo, hi, care, len);
			nbuf = $urandom_range(1, 6);
			for (int k = 0; k < nbuf && sent < ITEM_TARGET; k++) begin
				blen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
					: $urandom_range(1, 24);
				send_buffer(blen, k < nbuf - 1 || $urandom_range(0, 3) != 0);
			end
			calm = sent >= CALM_AFTER;
		end

		// close whatever buffer is still open, then wait for the last report
		send_buffer(1, 1'b1);
		drain_results();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
